FILE: hw/rtl/edu_pkg.sv
`timescale 1ns / 1ps

package edu_pkg;

    localparam int ELEM_W     = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = 42;
    localparam int FRAC_W     = 16;
    localparam int DIST_W     = 37;
    localparam int ROOT_STEPS = (SUM_W + 2 * FRAC_W + 1) / 2 + 1;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int REM_W      = ROOT_W + 2;
    // integer radicand pairs, leading zero pair included; fractional zeros follow
    localparam int RAD_W      = 2 * ROOT_STEPS - 2 * FRAC_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS + 1);

    typedef enum logic [1:0] {
        ST_ACCUM = 2'b01,
        ST_ROOT  = 2'b10
    } edu_state_t;

    typedef struct packed {
        logic acc_en;
        logic root_start;
        logic root_step;
        logic out_load;
    } edu_cmd_t;

    typedef struct packed {
        logic root_done;
    } edu_sts_t;

endpackage

FILE: hw/rtl/edu_in_if.sv
`timescale 1ns / 1ps

interface edu_in_if
    import edu_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last;

    modport source (output valid, output elem_a, output elem_b, output last, input ready);
    modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

FILE: hw/rtl/edu_out_if.sv
`timescale 1ns / 1ps

interface edu_out_if
    import edu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              saturated;

    modport source (output valid, output distance, output saturated, input ready);
    modport sink   (input valid, input distance, input saturated, output ready);
endinterface

FILE: hw/rtl/edu_ctrl.sv
`timescale 1ns / 1ps

module edu_ctrl
    import edu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    input  logic     out_ready,
    output logic     out_valid,
    input  edu_sts_t sts,
    output edu_cmd_t cmd
);

    edu_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                in_ready = 1'b1;
            end
            ST_ROOT:
            begin
                // keep taking pairs of the next vector, but hold its last beat
                in_ready = ~in_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase

        accept         = in_valid & in_ready;
        cmd.acc_en     = accept;
        cmd.root_start = accept & in_last;

        case (state_reg)
            ST_ACCUM:
            begin
                if (cmd.root_start)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.root_step = ~sts.root_done;
                if (sts.root_done && (!out_valid_reg || out_ready))
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/edu_dp.sv
`timescale 1ns / 1ps

module edu_dp
    import edu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  edu_cmd_t                 cmd,
    output edu_sts_t                 sts,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    output logic [DIST_W-1:0]        distance,
    output logic                     saturated
);

    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic              ovf_reg, ovf_next;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic              root_sat_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              sat_reg;

    logic [ELEM_W:0]   diff;
    logic [ELEM_W:0]   diff_abs;
    logic [MAG_W-1:0]  mag;
    logic [SQ_W-1:0]   sq;
    logic [SUM_W:0]    sum_wide;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb
    begin
        diff     = {elem_a[ELEM_W-1], elem_a} - {elem_b[ELEM_W-1], elem_b};
        diff_abs = diff[ELEM_W] ? (~diff + 1'b1) : diff;
        mag      = diff_abs[MAG_W-1:0];
        sq       = mag * mag;
        sum_wide = {1'b0, acc_reg} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq};
        // clamp at full scale on carry out
        acc_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        ovf_next = ovf_reg | sum_wide[SUM_W];

        // one restoring step: bring down the next radicand pair, try 4*root+1
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.root_start)
            begin
                acc_reg <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= CNT_W'(ROOT_STEPS);
            end
            else
            begin
                if (cmd.acc_en)
                begin
                    acc_reg <= acc_next;
                    ovf_reg <= ovf_next;
                end
                if (cmd.root_step)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_start)
        begin
            rad_reg      <= {{(RAD_W - SUM_W){1'b0}}, acc_next};
            rem_reg      <= '0;
            root_reg     <= '0;
            root_sat_reg <= ovf_next;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end

        if (cmd.out_load)
        begin
            dist_reg <= root_reg[DIST_W-1:0];
            sat_reg  <= root_sat_reg;
        end
    end

    assign sts.root_done = (cnt_reg == '0);
    assign distance      = dist_reg;
    assign saturated     = sat_reg;

endmodule

FILE: hw/rtl/euclidean_distance_unit_core.sv
`timescale 1ns / 1ps
// Euclidean distance unit. Element pairs of two signed 16-bit vectors arrive one
// beat per cycle; each beat adds the squared difference into a 42-bit accumulator
// that clamps at full scale and flags saturation. The beat marked last ends the
// vector: the sum goes to a restoring square-root unit that settles one root bit
// per cycle, and the result (U21.16, truncated) is loaded into the output
// register once the previous result there has been taken. Pairs of the next
// vector keep flowing at one per cycle while the root is computed; only its last
// beat waits until the previous root has been written to the output register, so
// a stream of long vectors runs at one pair per cycle while results are taken.

module euclidean_distance_unit_core
    import edu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    edu_in_if.sink    pairs,
    edu_out_if.source result
);

    edu_cmd_t cmd;
    edu_sts_t sts;

    edu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pairs.valid),
        .in_last   (pairs.last),
        .in_ready  (pairs.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    edu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .elem_a    (pairs.elem_a),
        .elem_b    (pairs.elem_b),
        .distance  (result.distance),
        .saturated (result.saturated)
    );

endmodule
